// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MEXP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mexp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MEXP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mexp assertion failed");

`endif

// ----- sv/mexp_pkg.sv -----
// shared types, sizes and modular helper functions for the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int unsigned WIDTH = 62;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // datapath operation chosen by the sequencer each cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_REDUCE,
    OP_SETUP,
    OP_MUL,
    OP_COMMIT,
    OP_FINISH
  } op_e;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic quick;     // zero modulus or zero exponent: result known at load
    logic exp_last;  // current exponent bit is the highest set one
  } stat_t;

  // a + x reduced once by m, with a and x below m
  function automatic word_t mod_add(word_t a, word_t x, word_t m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] t;
    s = {1'b0, a} + {1'b0, x};
    t = s - {1'b0, m};
    return (s >= {1'b0, m}) ? t[WIDTH-1:0] : s[WIDTH-1:0];
  endfunction

  // 2x + cin reduced once by m, with x below m
  function automatic word_t mod_dbl(word_t x, logic cin, word_t m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] t;
    s = {x, cin};
    t = s - {1'b0, m};
    return (s >= {1'b0, m}) ? t[WIDTH-1:0] : s[WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/mexp_in_if.sv -----
// input channel: valid/ready handshake carrying base, exponent and modulus
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mexp_in_if;
  logic            valid;
  logic            ready;
  mexp_pkg::word_t base;
  mexp_pkg::word_t exponent;
  mexp_pkg::word_t modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

`default_nettype wire

// ----- sv/mexp_out_if.sv -----
// output channel: valid/ready handshake carrying the power result
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mexp_out_if;
  logic            valid;
  logic            ready;
  mexp_pkg::word_t power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

// ----- sv/mexp_dp.sv -----
// datapath: operand registers around parallel modular add and double steps
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp (
  input  wire logic            clk_i,
  input  wire mexp_pkg::op_e   op_i,
  input  wire mexp_pkg::word_t base_i,
  input  wire mexp_pkg::word_t exponent_i,
  input  wire mexp_pkg::word_t modulus_i,
  output mexp_pkg::stat_t      stat_o,
  output mexp_pkg::word_t      result_o
);

  mexp_pkg::word_t m_q, e_q, b_q, pw_q, ans_q;
  mexp_pkg::word_t acc_a_q, acc_p_q, xa_q, xp_q, y_q, res_q;
  mexp_pkg::word_t ans_init;

  // zero modulus wins over zero exponent, zero exponent gives one even for modulus one, else modulus one gives zero
  always_comb begin
    if (modulus_i == '0) begin
      ans_init = '0;
    end else if (exponent_i == '0) begin
      ans_init = mexp_pkg::word_t'(1);
    end else if (modulus_i == mexp_pkg::word_t'(1)) begin
      ans_init = '0;
    end else begin
      ans_init = mexp_pkg::word_t'(1);
    end
  end

  assign stat_o.quick    = (modulus_i == '0) || (exponent_i == '0);
  assign stat_o.exp_last = (e_q[mexp_pkg::WIDTH-1:1] == '0);
  assign result_o        = res_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      mexp_pkg::OP_LOAD: begin
        m_q   <= modulus_i;
        e_q   <= exponent_i;
        b_q   <= base_i;
        pw_q  <= '0;
        ans_q <= ans_init;
      end
      // restoring reduction of the base, one bit per cycle
      mexp_pkg::OP_REDUCE: begin
        pw_q <= mexp_pkg::mod_dbl(pw_q, b_q[mexp_pkg::WIDTH-1], m_q);
        b_q  <= {b_q[mexp_pkg::WIDTH-2:0], 1'b0};
      end
      mexp_pkg::OP_SETUP: begin
        acc_a_q <= '0;
        acc_p_q <= '0;
        xa_q    <= ans_q;
        xp_q    <= pw_q;
        y_q     <= pw_q;
      end
      // ans*pw and pw*pw share the multiplier bits of pw
      mexp_pkg::OP_MUL: begin
        if (y_q[0]) begin
          acc_a_q <= mexp_pkg::mod_add(acc_a_q, xa_q, m_q);
          acc_p_q <= mexp_pkg::mod_add(acc_p_q, xp_q, m_q);
        end
        xa_q <= mexp_pkg::mod_dbl(xa_q, 1'b0, m_q);
        xp_q <= mexp_pkg::mod_dbl(xp_q, 1'b0, m_q);
        y_q  <= {1'b0, y_q[mexp_pkg::WIDTH-1:1]};
      end
      mexp_pkg::OP_COMMIT: begin
        if (e_q[0]) begin
          ans_q <= acc_a_q;
        end
        pw_q <= acc_p_q;
        e_q  <= {1'b0, e_q[mexp_pkg::WIDTH-1:1]};
      end
      mexp_pkg::OP_FINISH: begin
        res_q <= ans_q;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/mexp_ctrl.sv -----
// sequencer: walks load, base reduction and one multiply pass per exponent bit
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire mexp_pkg::stat_t stat_i,
  output mexp_pkg::op_e        op_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SETUP,
    ST_MUL,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e         state_q, state_d;
  mexp_pkg::cnt_t cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic           cnt_last;

  assign cnt_last    = (cnt_q == mexp_pkg::cnt_t'(mexp_pkg::WIDTH - 1));
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_o        = mexp_pkg::OP_HOLD;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = mexp_pkg::OP_LOAD;
          cnt_d   = '0;
          state_d = stat_i.quick ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        op_o  = mexp_pkg::OP_REDUCE;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        op_o    = mexp_pkg::OP_SETUP;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        op_o  = mexp_pkg::OP_MUL;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        op_o    = mexp_pkg::OP_COMMIT;
        state_d = stat_i.exp_last ? ST_FINISH : ST_SETUP;
      end
      ST_FINISH: begin
        // move into the output register once it is free or being drained
        if (!out_valid_q || out_ready_i) begin
          op_o        = mexp_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/modular_exponentiation_top.sv -----
// top level of the modular exponentiation block: sequencer plus shared datapath
// depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_ctrl, mexp_dp
//
//   channel  dir  fields                       handshake
//   in_i     in   base, exponent, modulus      valid/ready, sink modport
//   out_o    out  power_result                 valid/ready, source modport
//
// one item at a time: for a zero modulus or zero exponent an item passes only through
// accept and result load; otherwise through accept and base reduction, then a setup,
// multiply pass and commit for each exponent bit up to the highest set one, then result load
// the result is loaded at the edge that returns the sequencer to idle, so a new item is
// taken while it waits; a finished item holds in its last state while that result is unread
// asynchronous active-low reset clears only the sequencer and the output valid flag
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mexp_in_if.sink    in_i,
  mexp_out_if.source out_o
);

  mexp_pkg::op_e   op;
  mexp_pkg::stat_t stat;

  // sequencer: handshakes, step counter and the operation for each cycle
  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .op_o        (op)
  );

  // datapath: base reduction, then two modular products per exponent bit
  // (answer times power and power squared) built by shift-and-add
  mexp_dp u_dp (
    .clk_i      (clk_i),
    .op_i       (op),
    .base_i     (in_i.base),
    .exponent_i (in_i.exponent),
    .modulus_i  (in_i.modulus),
    .stat_o     (stat),
    .result_o   (out_o.power_result)
  );

endmodule

`default_nettype wire

// ----- sv/mexp_checker.sv -----
// port-level checks on the modular exponentiation top, attached by bind
// depends on mexp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mexp_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire mexp_pkg::word_t out_data_i
);

  // a held result stays offered
  `MEXP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a held result keeps its value
  `MEXP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

  // busy right after taking an item
  `MEXP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a fresh result is posted as the sequencer returns to idle
  `MEXP_ASSERT_NOW(a_result_then_idle, clk_i, rst_ni, $rose(out_valid_i), in_ready_i)

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.power_result)
);

`default_nettype wire
